// ===== sv/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
package i2cm_pkg;

    localparam int unsigned PHASE_TICKS_W = 16;
    localparam int unsigned POLL_W        = 8;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned BIT_CNT_W     = 4;

    localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RESET = 16'd500;
    localparam logic [POLL_W-1:0]        ACK_POLL_RESET    = 8'd250;
    localparam logic [BIT_CNT_W-1:0]     BITS_PER_BYTE     = 4'd8;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_ACK      = 3'd3,
        OP_NACK     = 3'd4,
        OP_WAIT_ACK = 3'd5,
        OP_WRITE    = 3'd6,
        OP_READ     = 3'd7
    } opcode_t;

    typedef enum logic {
        REG_PHASE_TICKS = 1'b0,
        REG_ACK_POLL    = 1'b1
    } reg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST0, PH_ST1, PH_ST2,
        PH_SP0, PH_SP1, PH_SP2,
        PH_AK0, PH_AK1, PH_AK2,
        PH_WA0, PH_WA1, PH_POLL,
        PH_WR0, PH_WR1, PH_WR2, PH_WR3,
        PH_RD0, PH_RD1
    } phase_t;

    typedef struct packed {
        logic drv;
        logic sda;
        logic scl;
    } lines_t;

    typedef struct packed {
        logic              is_cmd;
        phase_t            first_phase;
        logic              pend_we;
        logic              pend_val;
        logic              shift_we;
        logic [BYTE_W-1:0] shift_val;
        logic              sda_in;
    } item_t;

endpackage

// ===== sv/i2cm_front.sv =====
// Front end: accepts tick transactions and classifies the command they carry.
module i2cm_front (
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_opcode,
    input  logic [i2cm_pkg::BYTE_W-1:0] s_tx_byte,
    input  logic                      s_ack_after_read,
    input  logic                      s_sda_in,
    output logic                      q_valid,
    input  logic                      q_ready,
    output i2cm_pkg::item_t           q_item
);
    import i2cm_pkg::*;

    assign s_ready = q_ready;
    assign q_valid = s_valid;

    always_comb begin
        q_item             = '0;
        q_item.is_cmd      = 1'b1;
        q_item.first_phase = PH_IDLE;
        q_item.sda_in      = s_sda_in;
        unique case (opcode_t'(s_opcode))
            OP_NONE:     q_item.is_cmd = 1'b0;
            OP_START:    q_item.first_phase = PH_ST0;
            OP_STOP:     q_item.first_phase = PH_SP0;
            OP_ACK: begin
                q_item.first_phase = PH_AK0;
                q_item.pend_we     = 1'b1;
                q_item.pend_val    = 1'b1;
            end
            OP_NACK: begin
                q_item.first_phase = PH_AK0;
                q_item.pend_we     = 1'b1;
                q_item.pend_val    = 1'b0;
            end
            OP_WAIT_ACK: q_item.first_phase = PH_WA0;
            OP_WRITE: begin
                q_item.first_phase = PH_WR0;
                q_item.shift_we    = 1'b1;
                q_item.shift_val   = s_tx_byte;
            end
            OP_READ: begin
                q_item.first_phase = PH_RD0;
                q_item.pend_we     = 1'b1;
                q_item.pend_val    = s_ack_after_read;
                q_item.shift_we    = 1'b1;
                q_item.shift_val   = '0;
            end
            default:     q_item.is_cmd = 1'b0;
        endcase
    end

endmodule

// ===== sv/i2cm_queue.sv =====
// Two-entry queue between the front end and the line sequencer.
module i2cm_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  i2cm_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output i2cm_pkg::item_t out_item
);
    import i2cm_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/i2cm_back.sv =====
// Back end: phase sequencer driving SCL and SDA, with the result register.
module i2cm_back #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [i2cm_pkg::PHASE_TICKS_W-1:0] phase_ticks,
    input  logic [i2cm_pkg::POLL_W-1:0]      ack_poll_limit,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  i2cm_pkg::item_t                  q_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_scl_level,
    output logic                             m_sda_level,
    output logic                             m_sda_drive,
    output logic                             m_busy_res,
    output logic                             m_done_res,
    output logic                             m_ack_failed,
    output logic [i2cm_pkg::BYTE_W-1:0]      m_rx_byte
);
    import i2cm_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]  delay_count_reg, delay_count_next;
    logic [BIT_CNT_W-1:0]    bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]       shift_reg, shift_next;
    logic [POLL_W-1:0]       poll_count_reg, poll_count_next;
    logic                    pending_ack_reg, pending_ack_next;
    lines_t                  lines_reg, lines_next;
    logic                    fail_reg, fail_next;
    logic [BYTE_W-1:0]       rx_hold_reg, rx_hold_next;

    logic                    out_valid_reg;
    lines_t                  out_lines_reg;
    logic                    out_busy_reg;
    logic                    out_done_reg;
    logic                    out_fail_reg;
    logic [BYTE_W-1:0]       out_rx_reg;

    logic                    pop;
    logic                    enter;
    logic                    expire;
    logic                    done;
    logic                    byte_end;
    logic [PHASE_TICKS_W+COUNT_WIDTH-1:0] ticks_ext;
    logic [COUNT_WIDTH-1:0]  ticks_masked;
    logic [COUNT_WIDTH-1:0]  phase_load;

    function automatic lines_t enter_lines(phase_t p, lines_t cur, logic pend,
                                           logic [BYTE_W-1:0] sh);
        lines_t l;
        l = cur;
        unique case (p)
            PH_ST0:  l = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
            PH_ST1:  l = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
            PH_ST2:  l = '{drv: 1'b1, sda: 1'b0, scl: 1'b0};
            PH_SP0:  l = '{drv: 1'b1, sda: 1'b0, scl: 1'b0};
            PH_SP1:  l = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
            PH_SP2:  l = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
            PH_AK0:  l = '{drv: 1'b1, sda: !pend, scl: 1'b0};
            PH_AK1:  l.scl = 1'b1;
            PH_AK2:  l.scl = 1'b0;
            PH_WA0:  l = '{drv: 1'b0, sda: 1'b1, scl: cur.scl};
            PH_WA1:  l.scl = 1'b1;
            PH_WR0:  l = '{drv: 1'b1, sda: sh[BYTE_W-1], scl: 1'b0};
            PH_WR2:  l.scl = 1'b1;
            PH_WR3:  l.scl = 1'b0;
            PH_RD0:  l = '{drv: 1'b0, sda: 1'b1, scl: 1'b0};
            PH_RD1:  l = '{drv: 1'b0, sda: 1'b1, scl: 1'b1};
            default: l = cur;
        endcase
        return l;
    endfunction

    assign pop          = q_valid && (!out_valid_reg || m_ready);
    assign q_ready      = !out_valid_reg || m_ready;
    assign expire       = (delay_count_reg <= COUNT_WIDTH'(1));
    assign byte_end     = (bit_count_reg >= BITS_PER_BYTE);
    assign ticks_ext    = {{COUNT_WIDTH{1'b0}}, phase_ticks};
    assign ticks_masked = ticks_ext[COUNT_WIDTH-1:0];
    assign phase_load   = (ticks_masked == '0) ? COUNT_WIDTH'(1) : ticks_masked;
    assign done         = pop && (phase_reg != PH_IDLE) && (phase_next == PH_IDLE);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        enter      = 1'b0;
        if (pop) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (q_item.is_cmd) begin
                        phase_next = q_item.first_phase;
                        enter      = 1'b1;
                    end
                end
                PH_POLL: begin
                    if (!q_item.sda_in) begin
                        phase_next = PH_IDLE;
                    end else if (poll_count_reg >= ack_poll_limit) begin
                        phase_next = PH_SP0;
                        enter      = 1'b1;
                    end
                end
                default: begin
                    if (expire) begin
                        enter = 1'b1;
                        case (phase_reg)
                            PH_ST0: phase_next = PH_ST1;
                            PH_ST1: phase_next = PH_ST2;
                            PH_SP0: phase_next = PH_SP1;
                            PH_SP1: phase_next = PH_SP2;
                            PH_AK0: phase_next = PH_AK1;
                            PH_AK1: phase_next = PH_AK2;
                            PH_WA0: phase_next = PH_WA1;
                            PH_WA1: begin
                                phase_next = PH_POLL;
                                enter      = 1'b0;
                            end
                            PH_WR0: phase_next = PH_WR1;
                            PH_WR1: phase_next = PH_WR2;
                            PH_WR2: phase_next = PH_WR3;
                            PH_WR3: begin
                                phase_next = byte_end ? PH_IDLE : PH_WR0;
                                enter      = !byte_end;
                            end
                            PH_RD0: phase_next = PH_RD1;
                            PH_RD1: phase_next = byte_end ? PH_AK0 : PH_RD0;
                            default: begin
                                phase_next = PH_IDLE;
                                enter      = 1'b0;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // datapath and line levels
    always_comb begin
        delay_count_next = delay_count_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        poll_count_next  = poll_count_reg;
        pending_ack_next = pending_ack_reg;
        lines_next       = lines_reg;
        fail_next        = fail_reg;
        rx_hold_next     = rx_hold_reg;
        if (pop) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (q_item.is_cmd) begin
                        fail_next       = 1'b0;
                        bit_count_next  = '0;
                        poll_count_next = '0;
                        if (q_item.pend_we) begin
                            pending_ack_next = q_item.pend_val;
                        end
                        if (q_item.shift_we) begin
                            shift_next = q_item.shift_val;
                        end
                    end
                end
                PH_POLL: begin
                    if (!q_item.sda_in) begin
                        lines_next.scl = 1'b0;
                    end else if (poll_count_reg >= ack_poll_limit) begin
                        fail_next = 1'b1;
                    end else begin
                        poll_count_next = poll_count_reg + 1'b1;
                    end
                end
                default: begin
                    if (!expire) begin
                        delay_count_next = delay_count_reg - 1'b1;
                    end else begin
                        case (phase_reg)
                            PH_WA1: poll_count_next = '0;
                            PH_WR2: begin
                                shift_next     = {shift_reg[BYTE_W-2:0], 1'b0};
                                bit_count_next = bit_count_reg + 1'b1;
                            end
                            PH_RD0: begin
                                shift_next     = {shift_reg[BYTE_W-2:0], q_item.sda_in};
                                bit_count_next = bit_count_reg + 1'b1;
                            end
                            PH_RD1: begin
                                if (byte_end) begin
                                    rx_hold_next = shift_reg;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
            if (enter) begin
                delay_count_next = phase_load;
                lines_next = enter_lines(phase_next, lines_reg, pending_ack_next, shift_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            delay_count_reg <= '0;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            poll_count_reg  <= '0;
            pending_ack_reg <= 1'b0;
            lines_reg       <= '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
            fail_reg        <= 1'b0;
            rx_hold_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            delay_count_reg <= delay_count_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            poll_count_reg  <= poll_count_next;
            pending_ack_reg <= pending_ack_next;
            lines_reg       <= lines_next;
            fail_reg        <= fail_next;
            rx_hold_reg     <= rx_hold_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_lines_reg <= lines_next;
            out_busy_reg  <= (phase_next != PH_IDLE);
            out_done_reg  <= done;
            out_fail_reg  <= fail_next;
            out_rx_reg    <= rx_hold_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_scl_level  = out_lines_reg.scl;
    assign m_sda_level  = out_lines_reg.sda;
    assign m_sda_drive  = out_lines_reg.drv;
    assign m_busy_res   = out_busy_reg;
    assign m_done_res   = out_done_reg;
    assign m_ack_failed = out_fail_reg;
    assign m_rx_byte    = out_rx_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_done_reg |-> !out_busy_reg)
        else $error("done reported while still busy");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= BITS_PER_BYTE)
        else $error("bit counter past one byte");

    a_poll_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_POLL |-> poll_count_reg <= ack_poll_limit)
        else $error("ack poll counter past limit");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> $stable(phase_reg) && $stable(lines_reg))
        else $error("sequencer advanced while result stalled");

endmodule

// ===== sv/i2c_master_bit_sequencer_unit.sv =====
// Top level of the I2C master bit sequencer: register port and front/back assembly.
//
// Each s_ transaction is one bus tick carrying an optional command (start, stop,
// ack, nack, wait ack, write byte, read byte). Every accepted tick yields exactly
// one m_ transaction with the SCL/SDA levels, SDA drive, busy, done, ack failure
// and last received byte as they stand after that tick.
// Phase length (phase_ticks, address 0) and ack poll limit (ack_poll_limit,
// address 4) must be written over the APB port only while the block is idle;
// the block does not enforce this. pready is always high and reads return the
// register value. An accepted tick is written into the command queue, then the
// sequencer steps it into the result register that drives m_.
// The sequencer takes one tick per cycle while the result register is empty or
// m_ready is high.
// When m_ready is low the result register holds, the queue absorbs up to two
// more ticks, then s_ready drops until the receiver takes the result.
// Reset (aresetn low, synchronous) returns the sequencer to idle with SCL and
// SDA high and driven, empties the queue and restores register defaults.
module i2c_master_bit_sequencer_unit #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_opcode,
    input  logic [i2cm_pkg::BYTE_W-1:0]        s_tx_byte,
    input  logic                               s_ack_after_read,
    input  logic                               s_sda_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_scl_level,
    output logic                               m_sda_level,
    output logic                               m_sda_drive,
    output logic                               m_busy_res,
    output logic                               m_done_res,
    output logic                               m_ack_failed,
    output logic [i2cm_pkg::BYTE_W-1:0]        m_rx_byte
);
    import i2cm_pkg::*;

    logic [PHASE_TICKS_W-1:0] phase_ticks_reg;
    logic [POLL_W-1:0]        ack_poll_limit_reg;
    logic                     cfg_write;
    reg_idx_t                 reg_idx;

    logic  fq_valid, fq_ready;
    item_t fq_item;
    logic  qb_valid, qb_ready;
    item_t qb_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg    <= PHASE_TICKS_RESET;
            ack_poll_limit_reg <= ACK_POLL_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PHASE_TICKS: phase_ticks_reg    <= pwdata[PHASE_TICKS_W-1:0];
                REG_ACK_POLL:    ack_poll_limit_reg <= pwdata[POLL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PHASE_TICKS: prdata = 32'(phase_ticks_reg);
            REG_ACK_POLL:    prdata = 32'(ack_poll_limit_reg);
            default:         prdata = '0;
        endcase
    end

    i2cm_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_tx_byte        (s_tx_byte),
        .s_ack_after_read (s_ack_after_read),
        .s_sda_in         (s_sda_in),
        .q_valid          (fq_valid),
        .q_ready          (fq_ready),
        .q_item           (fq_item)
    );

    i2cm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    i2cm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .phase_ticks    (phase_ticks_reg),
        .ack_poll_limit (ack_poll_limit_reg),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_item         (qb_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_level    (m_scl_level),
        .m_sda_level    (m_sda_level),
        .m_sda_drive    (m_sda_drive),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_ack_failed   (m_ack_failed),
        .m_rx_byte      (m_rx_byte)
    );

endmodule
